// ===== hdl/aes_pkg.sv =====
// Package: AES-128 types, S-box, round constants and round helper functions.
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] blk_t;

  typedef logic [0:9][7:0] rcon_arr_t;
  localparam rcon_arr_t Rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } cfg_reg_e;

  // Data and key travelling from one round cell to the next.
  typedef struct packed {
    logic vld;
    blk_t state;
    blk_t rkey;
  } cell_bus_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  // Byte i of a block; byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c + r) % 4) + r));
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // One step of the key schedule.
  function automatic blk_t next_key(input blk_t p, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = p[127:96];
    w1 = p[95:64];
    w2 = p[63:32];
    w3 = p[31:0];
    tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== hdl/aes_round_cell.sv =====
// One round cell: a cipher round plus the matching key schedule step.
module aes_round_cell import aes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       last_i,
  input  logic [7:0] rcon_i,
  input  cell_bus_t  in_i,
  output cell_bus_t  out_o
);

  blk_t sb_d, rk_d, st_d;
  logic vld_q;
  blk_t st_q, rk_q;

  always_comb begin
    sb_d = sub_shift(in_i.state);
    rk_d = next_key(in_i.rkey, rcon_i);
    st_d = (last_i ? sb_d : mix_cols(sb_d)) ^ rk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
      rk_q <= rk_d;
    end
  end

  assign out_o = '{vld: vld_q, state: st_q, rkey: rk_q};

endmodule

// ===== hdl/aes128_block_encrypt_unit.sv =====
// Top level: AES-128 encryptor as a chain of ten round cells.
// Pipeline: a registered whitening stage followed by the ten registered round cells.
// Throughput: one block per cycle; the whole chain advances together and halts
//   only when the last cell holds a beat that the sink has not taken.
// Reset: rst_ni clears all valid bits and both key registers to zero.
// The key is sampled at the input beat and travels down the chain with its block.
module aes128_block_encrypt_unit import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key_hi_q, key_lo_q;
  logic        adv;
  cell_bus_t   chain [NumRounds+1];
  logic        vld0_q;
  blk_t        st0_q, rk0_q;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyHigh: key_hi_q <= cfg_data_i;
        RegKeyLow:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chain moves whenever the output slot is empty or being drained.
  assign adv     = !chain[NumRounds].vld || ready_i;
  assign ready_o = adv;

  // Whitening stage: initial AddRoundKey.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= {plain_high_i, plain_low_i} ^ {key_hi_q, key_lo_q};
      rk0_q <= {key_hi_q, key_lo_q};
    end
  end

  assign chain[0] = '{vld: vld0_q, state: st0_q, rkey: rk0_q};

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .last_i (g == NumRounds - 1),
      .rcon_i (Rcon[g]),
      .in_i   (chain[g]),
      .out_o  (chain[g+1])
    );
  end

  assign valid_o       = chain[NumRounds].vld;
  assign cipher_high_o = chain[NumRounds].state[127:64];
  assign cipher_low_o  = chain[NumRounds].state[63:0];

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(cipher_high_o) && $stable(cipher_low_o))
    else $error("result changed while stalled");

  // Input is taken exactly when the chain can move.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_o && !ready_i)
    else $error("ready low without output stall");

  // A beat entering reaches the whitening stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> chain[0].vld)
    else $error("accepted beat lost");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the AES-128 block encryption unit: random and directed blocks checked
// against a behavioral AES-128 predictor.
`timescale 1ns / 100ps

module testbench;
  import aes_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [63:0] plain_high_i = '0;
  logic [63:0] plain_low_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes128_block_encrypt_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: our own copy of the key registers.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  block_t plain_q[$];        // blocks waiting to be driven
  block_t cipher_exp_q[$];   // ciphertexts expected, oldest first
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;

  // S-box lookup table, built once from the GF(2^8) inverse plus affine map.
  logic [7:0] sbox_lut[256];

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      end
      s = inv;
      for (int k = 1; k < 5; k++) s ^= (inv << k) | (inv >> (8 - k));
      sbox_lut[x] = s ^ 8'h63;
    end
  end

  // Full AES-128 encryption of one block under the current key copy.
  function automatic block_t aes_encrypt(block_t pt);
    logic [7:0] st[16], tmp[16], rk[16], nk[16];
    logic [7:0] rc, a0, a1, a2, a3, al;
    block_t res;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i] = key_hi_q[63-8*i -: 8];
      rk[i+8] = key_lo_q[63-8*i -: 8];
      st[i] = pt.hi[63-8*i -: 8] ^ rk[i];
      st[i+8] = pt.lo[63-8*i -: 8] ^ rk[i+8];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // next round key
      nk[0] = rk[0] ^ sbox_lut[rk[13]] ^ rc;
      nk[1] = rk[1] ^ sbox_lut[rk[14]];
      nk[2] = rk[2] ^ sbox_lut[rk[15]];
      nk[3] = rk[3] ^ sbox_lut[rk[12]];
      for (int i = 4; i < 16; i++) nk[i] = nk[i-4] ^ rk[i];
      rk = nk;
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      // SubBytes + ShiftRows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
      st = tmp;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
          st[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
          st[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
          st[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[i+8];
    end
    return res;
  endfunction

  // Mostly no gap at all, often a short one, and now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: pops the pending queue; the expectation is logged at the beat.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        cipher_exp_q.push_back(aes_encrypt({plain_high_i, plain_low_i}));
      end
      if (!valid_i || ready_o) begin
        if (send_gap == 0 && plain_q.size() > 0) begin
          block_t b;
          b = plain_q.pop_front();
          valid_i <= 1'b1;
          plain_high_i <= b.hi;
          plain_low_i <= b.lo;
          send_gap <= pick_gap();
        end else begin
          valid_i <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each output beat with the oldest expectation.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (cipher_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output beat: %h %h", cipher_high_o, cipher_low_o);
        end else begin
          block_t e;
          e = cipher_exp_q.pop_front();
          if (e.hi !== cipher_high_o || e.lo !== cipher_low_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cipher mismatch: exp %h %h got %h %h",
                       e.hi, e.lo, cipher_high_o, cipher_low_o);
          end
        end
      end
      if (stall_left > 0) begin
        ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        ready_i <= 1'b1;
        stall_left <= pick_gap();
      end
      // watchdog on either side making progress
      if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegKeyHigh) key_hi_q = val;
    else key_lo_q = val;
  endtask

  // Wait until every queued block has been driven and every expectation met,
  // then let the pipeline empty out. Checked on the falling edge so that the
  // driver and monitor updates of the rising edge have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (plain_q.size() > 0 || valid_i || cipher_exp_q.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    block_t b;
    for (int unsigned i = 0; i < n; i++) begin
      b.hi = rand64();
      b.lo = rand64();
      plain_q.push_back(b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All-zero key straight out of reset, with extreme plaintexts.
    plain_q.push_back('{64'h0, 64'h0});
    plain_q.push_back('{'1, '1});
    plain_q.push_back('{'1, 64'h0});
    plain_q.push_back('{64'h8000_0000_0000_0000, 64'h1});
    wait_drained();

    // FIPS-197 appendix vector key, then the matching plaintext.
    write_reg(RegKeyHigh, 64'h0001_0203_0405_0607);
    write_reg(RegKeyLow, 64'h0809_0a0b_0c0d_0e0f);
    plain_q.push_back('{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{64'h0, 64'h0});
    plain_q.push_back('{'1, '1});
    wait_drained();

    // All-ones key.
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    plain_q.push_back('{64'h0, 64'h0});
    plain_q.push_back('{'1, '1});
    plain_q.push_back('{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
    wait_drained();

    // Random phases, each with a fresh random key.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegKeyHigh, rand64());
      write_reg(RegKeyLow, rand64());
      queue_random(125);
      wait_drained();
    end

    // Back to zero key, a short burst at the end.
    write_reg(RegKeyHigh, 64'h0);
    write_reg(RegKeyLow, 64'h0);
    queue_random(20);
    wait_drained();

    if (mismatches == 0 && cipher_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/aes_pkg.sv
hdl/aes_round_cell.sv
hdl/aes128_block_encrypt_unit.sv
dv/testbench.sv
